>>> design/u8v_pkg.sv
// shared types and constants of the utf-8 stream validator
package u8v_pkg;

    // lead byte ranges
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;

    // continuation byte tag, top two bits
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // code point limits
    localparam logic [20:0] MIN2       = 21'h00080;
    localparam logic [20:0] MIN3       = 21'h00800;
    localparam logic [20:0] MIN4       = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h0D800;
    localparam logic [20:0] SURR_HI    = 21'h0DFFF;

    // report kinds
    localparam logic KIND_ERROR   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // verdict of the sequence checker on the bytes at the scan position
    typedef struct packed {
        logic       need_more;
        logic       invalid;
        logic [2:0] width;
    } t_chk;

    // one result word
    typedef struct packed {
        logic        kind;
        logic [31:0] offset;
        logic [31:0] total;
        logic        last;
    } t_result;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

endpackage

>>> design/u8v_check.sv
// sequence checker: judges the utf-8 sequence starting at the first buffered byte
module u8v_check (
    input  logic [3:0][7:0]  i_bytes,
    input  logic [2:0]       i_avail,
    output u8v_pkg::t_chk    o_chk
);

    logic [7:0]  lead;
    logic [2:0]  width;
    logic        bad_lead;
    logic [20:0] value;
    logic [20:0] minimum;
    logic        cont_ok;
    logic        range_ok;

    assign lead = i_bytes[0];

    // classify the lead byte
    always_comb begin
        bad_lead = 1'b0;
        width    = 3'd1;
        minimum  = '0;
        if (lead < u8v_pkg::ASCII_LIMIT) begin
            width = 3'd1;
        end else if (lead >= u8v_pkg::LEAD2_LO && lead <= u8v_pkg::LEAD2_HI) begin
            width   = 3'd2;
            minimum = u8v_pkg::MIN2;
        end else if (lead >= u8v_pkg::LEAD3_LO && lead <= u8v_pkg::LEAD3_HI) begin
            width   = 3'd3;
            minimum = u8v_pkg::MIN3;
        end else if (lead >= u8v_pkg::LEAD4_LO && lead <= u8v_pkg::LEAD4_HI) begin
            width   = 3'd4;
            minimum = u8v_pkg::MIN4;
        end else begin
            bad_lead = 1'b1;
        end
    end

    // continuation tags and decoded code point
    always_comb begin
        cont_ok = 1'b1;
        value   = '0;
        case (width)
            3'd2: begin
                cont_ok = (i_bytes[1][7:6] == u8v_pkg::CONT_TAG);
                value   = {10'd0, lead[4:0], i_bytes[1][5:0]};
            end
            3'd3: begin
                cont_ok = (i_bytes[1][7:6] == u8v_pkg::CONT_TAG) &&
                          (i_bytes[2][7:6] == u8v_pkg::CONT_TAG);
                value   = {5'd0, lead[3:0], i_bytes[1][5:0], i_bytes[2][5:0]};
            end
            3'd4: begin
                cont_ok = (i_bytes[1][7:6] == u8v_pkg::CONT_TAG) &&
                          (i_bytes[2][7:6] == u8v_pkg::CONT_TAG) &&
                          (i_bytes[3][7:6] == u8v_pkg::CONT_TAG);
                value   = {lead[2:0], i_bytes[1][5:0], i_bytes[2][5:0], i_bytes[3][5:0]};
            end
            default: begin
                cont_ok = 1'b1;
                value   = {13'd0, lead};
            end
        endcase
    end

    assign range_ok = (value >= minimum) && (value <= u8v_pkg::CP_MAX) &&
                      !((value >= u8v_pkg::SURR_LO) && (value <= u8v_pkg::SURR_HI));

    // verdict
    always_comb begin
        o_chk.width     = width;
        o_chk.need_more = 1'b0;
        o_chk.invalid   = 1'b0;
        if (bad_lead) begin
            o_chk.invalid = 1'b1;
        end else if (i_avail < width) begin
            o_chk.need_more = 1'b1;
        end else if (!cont_ok || !range_ok) begin
            o_chk.invalid = 1'b1;
        end
    end

endmodule

>>> design/u8v_out.sv
// output register for result words, drives the master stream side
module u8v_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  u8v_pkg::t_result i_word,
    output logic             o_free,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [63:0]      o_m_tdata,
    output logic             o_m_tuser,
    output logic             o_m_tlast
);

    logic             r_valid;
    u8v_pkg::t_result r_word;

    // the register can take a word when empty or draining
    assign o_free = !r_valid || i_m_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_word.total, r_word.offset};
    assign o_m_tuser  = r_word.kind;
    assign o_m_tlast  = r_word.last;

endmodule

>>> design/utf8_stream_validator.sv
// utf-8 stream validator top level: byte buffer, scan sequencer and counters
// Takes one text byte, then scans the buffered bytes through a single shared sequence
// checker, one sequence position per cycle while no held report waits on a full output
// register, and closes the scan with a final step. A byte that raises reports or ends
// the text also passes through the flush state, and each report waits while the output
// register is full and not being read.
// Synchronous active-low reset clears counters, buffer fill and sequencer; no clearing pass.
module utf8_stream_validator #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] error_offset, [63:32] error_total
    output logic        o_m_tuser,   // report_kind
    output logic        o_m_tlast    // last_of_run
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    u8v_pkg::t_state  r_state, n_state;
    logic [3:0][7:0]  r_buf, n_buf;
    logic [2:0]       r_n, n_n;
    logic             r_eot, n_eot;
    logic [OFFSET_BITS:0]   r_off, n_off;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [31:0]      r_err, n_err;
    logic             r_hold_v, n_hold_v;
    u8v_pkg::t_result r_hold, n_hold;

    u8v_pkg::t_chk    chk;
    logic             out_free;
    logic             out_load;
    u8v_pkg::t_result out_word;
    logic [OFFSET_BITS-1:0] off_sat;
    logic [63:0]      off_ext;
    logic [63:0]      pos_ext;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] base;
    logic [31:0]      err_inc;
    logic [2:0]       adv;
    logic             do_shift;
    logic             stall;

    // shared sequence checker on the head of the buffer
    u8v_check u_check (
        .i_bytes (r_buf),
        .i_avail (r_n),
        .o_chk   (chk)
    );

    u8v_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (out_load),
        .i_word     (out_word),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_s_tready = (r_state == u8v_pkg::S_IDLE);

    // saturating helpers and 64-bit views of offsets
    assign pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign base    = (r_pos >= OFFSET_BITS'(r_n)) ? r_pos - OFFSET_BITS'(r_n) : '0;
    assign err_inc = (r_err == u8v_pkg::COUNT_MAX) ? r_err : r_err + 32'd1;
    assign off_sat = r_off[OFFSET_BITS] ? POS_MAX : r_off[OFFSET_BITS-1:0];
    assign off_ext = 64'(off_sat);
    assign pos_ext = 64'(r_pos);
    assign stall   = r_hold_v && !out_free;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_buf    = r_buf;
        n_n      = r_n;
        n_eot    = r_eot;
        n_off    = r_off;
        n_pos    = r_pos;
        n_err    = r_err;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        out_load = 1'b0;
        out_word = r_hold;
        adv      = 3'd1;
        do_shift = 1'b0;
        case (r_state)
            u8v_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_buf[r_n[1:0]] = i_s_tdata;
                    n_n     = r_n + 3'd1;
                    n_eot   = i_s_tlast;
                    n_off   = {1'b0, base};
                    n_pos   = pos_inc;
                    n_state = u8v_pkg::S_SCAN;
                end
            end
            u8v_pkg::S_SCAN: begin
                if (!stall) begin
                    if (r_n == 3'd0 || (chk.need_more && !r_eot)) begin
                        // scan finished; what is left stays pending
                        if (r_eot) begin
                            if (r_hold_v) begin
                                out_load      = 1'b1;
                                out_word.last = 1'b0;
                            end
                            n_hold_v      = 1'b1;
                            n_hold.kind   = u8v_pkg::KIND_SUMMARY;
                            n_hold.offset = pos_ext[31:0];
                            n_hold.total  = r_err;
                            n_hold.last   = 1'b1;
                            n_pos   = '0;
                            n_err   = '0;
                            n_n     = 3'd0;
                            n_eot   = 1'b0;
                            n_state = u8v_pkg::S_FLUSH;
                        end else if (r_hold_v) begin
                            n_state = u8v_pkg::S_FLUSH;
                        end else begin
                            n_state = u8v_pkg::S_IDLE;
                        end
                    end else if (chk.invalid || chk.need_more) begin
                        // report the start byte and drop it
                        if (r_hold_v) begin
                            out_load      = 1'b1;
                            out_word.last = 1'b0;
                        end
                        n_hold_v      = 1'b1;
                        n_hold.kind   = u8v_pkg::KIND_ERROR;
                        n_hold.offset = off_ext[31:0];
                        n_hold.total  = err_inc;
                        n_hold.last   = 1'b1;
                        n_err    = err_inc;
                        adv      = 3'd1;
                        do_shift = 1'b1;
                    end else begin
                        adv      = chk.width;
                        do_shift = 1'b1;
                    end
                end
            end
            u8v_pkg::S_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = u8v_pkg::S_IDLE;
                end else if (out_free) begin
                    out_load      = 1'b1;
                    out_word.last = 1'b1;
                    n_hold_v      = 1'b0;
                    n_state       = u8v_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = u8v_pkg::S_IDLE;
            end
        endcase

        // move past the checked bytes
        if (do_shift) begin
            n_n   = r_n - adv;
            n_off = r_off + (OFFSET_BITS+1)'(adv);
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 4; j++) begin
                    if (j == k + int'(adv)) begin
                        n_buf[k] = r_buf[j];
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= u8v_pkg::S_IDLE;
            r_n      <= 3'd0;
            r_eot    <= 1'b0;
            r_pos    <= '0;
            r_err    <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_eot    <= n_eot;
            r_pos    <= n_pos;
            r_err    <= n_err;
            r_hold_v <= n_hold_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_buf  <= n_buf;
        r_off  <= n_off;
        r_hold <= n_hold;
    end

`ifndef SYNTHESIS
    // no result left waiting while a new byte can be taken
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_hold_v)
        else $error("held result while idle");

    // at most three bytes remain pending between input bytes
    a_idle_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u8v_pkg::S_IDLE) |-> (r_n <= 3'd3))
        else $error("pending buffer overfull");

    // a summary word clears the position and error count
    a_summary_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u8v_pkg::S_SCAN && n_hold.kind == u8v_pkg::KIND_SUMMARY &&
         n_hold_v && !r_hold_v) |=> (r_pos == '0 && r_err == '0 && r_n == 3'd0) ||
         (r_hold.kind != u8v_pkg::KIND_SUMMARY))
        else $error("counters not cleared after summary");

    // output word only loaded when the register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register overwritten");
`endif

endmodule

>>> tb/sv/tb_utf8_stream_validator.sv
// testbench of the utf-8 stream validator: byte driver, result monitor and checker
`timescale 1ns / 1ps

module tb_utf8_stream_validator;

    localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 480;    // directed part plus random texts, about 480 bytes
    localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       eot;
    } t_text_item;

    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} t_rx_mode;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;     // [7:0] text_byte
    logic        i_s_tlast  = 1'b0;   // end_of_text
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;           // [31:0] error_offset, [63:32] error_total
    logic        o_m_tuser;           // report_kind
    logic        o_m_tlast;           // last_of_run

    t_text_item          text_q[$];
    u8v_pkg::t_result    report_q[$];

    // scanner copy: buffered bytes, text position, error count
    logic [2:0][7:0] held_bytes;
    int unsigned     held_count = 0;
    logic [31:0]     text_pos   = '0;
    logic [31:0]     err_count  = '0;

    logic     took_byte  = 1'b0;
    int       bytes_in   = 0;
    int       mismatches = 0;
    int       quiet      = 0;
    int       burst_left = 0;
    int       gap_left   = 0;
    int       rx_cyc     = 0;
    int       hold_left  = 0;
    bit       held_off   = 1'b0;
    t_rx_mode rx_mode    = RX_ALWAYS;

    utf8_stream_validator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // width of a good sequence at the scan position, 0 if short, -1 if bad
    function automatic int seq_verdict(input logic [3:0][7:0] b, input int unsigned at,
                                       input int unsigned avail);
        logic [7:0]  lead;
        logic [7:0]  c;
        logic [20:0] cp;
        logic [20:0] floor_cp;
        int unsigned w;
        int unsigned k;
        lead = b[at];
        if (lead < u8v_pkg::ASCII_LIMIT) return 1;
        if (lead >= u8v_pkg::LEAD2_LO && lead <= u8v_pkg::LEAD2_HI) begin
            w = 2; cp = {16'b0, lead[4:0]}; floor_cp = u8v_pkg::MIN2;
        end else if (lead >= u8v_pkg::LEAD3_LO && lead <= u8v_pkg::LEAD3_HI) begin
            w = 3; cp = {17'b0, lead[3:0]}; floor_cp = u8v_pkg::MIN3;
        end else if (lead >= u8v_pkg::LEAD4_LO && lead <= u8v_pkg::LEAD4_HI) begin
            w = 4; cp = {18'b0, lead[2:0]}; floor_cp = u8v_pkg::MIN4;
        end else begin
            return -1;
        end
        if (avail < w) return 0;
        for (k = 1; k < w; k++) begin
            c = b[at + k];
            if (c[7:6] != u8v_pkg::CONT_TAG) return -1;
            cp = {cp[14:0], c[5:0]};
        end
        if (cp < floor_cp || cp > u8v_pkg::CP_MAX ||
            (cp >= u8v_pkg::SURR_LO && cp <= u8v_pkg::SURR_HI)) return -1;
        return int'(w);
    endfunction

    // reports raised by one accepted byte, queued in order
    task automatic predict_byte(input logic [7:0] data, input logic eot);
        logic [3:0][7:0]  scan_buf;
        longint unsigned  base;
        longint unsigned  off;
        int unsigned      n;
        int unsigned      i;
        int unsigned      k;
        int               verdict;
        int               first_idx;
        u8v_pkg::t_result r;
        first_idx = report_q.size();
        scan_buf  = '0;
        for (k = 0; k < held_count; k++) scan_buf[k] = held_bytes[k];
        scan_buf[held_count] = data;
        n    = held_count + 1;
        base = (text_pos >= held_count) ? longint'(text_pos) - held_count : 0;
        if (text_pos != POS_MAX) text_pos++;
        i = 0;
        while (i < n) begin
            verdict = seq_verdict(scan_buf, i, n - i);
            if (verdict == 0 && eot) verdict = -1;
            if (verdict == 0) break;
            if (verdict < 0) begin
                off = base + i;
                if (off > POS_MAX) off = POS_MAX;
                if (err_count != POS_MAX) err_count++;
                r.kind   = u8v_pkg::KIND_ERROR;
                r.offset = off[31:0];
                r.total  = err_count;
                r.last   = 1'b0;
                report_q.insert(report_q.size(), r);
                i++;
            end else begin
                i += verdict;
            end
        end
        held_count = n - i;
        for (k = 0; k < held_count; k++) held_bytes[k] = scan_buf[i + k];
        // end of text: summary, then a fresh text
        if (eot) begin
            r.kind   = u8v_pkg::KIND_SUMMARY;
            r.offset = text_pos;
            r.total  = err_count;
            r.last   = 1'b0;
            report_q.insert(report_q.size(), r);
            held_count = 0;
            text_pos   = '0;
            err_count  = '0;
        end
        if (report_q.size() > first_idx) report_q[$].last = 1'b1;
    endtask

    function automatic int encode_cp(input logic [20:0] cp, output logic [3:0][7:0] seq);
        seq = '0;
        if (cp < u8v_pkg::MIN2) begin
            seq[0] = cp[7:0];
            return 1;
        end
        if (cp < u8v_pkg::MIN3) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {u8v_pkg::CONT_TAG, cp[5:0]};
            return 2;
        end
        if (cp < u8v_pkg::MIN4) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {u8v_pkg::CONT_TAG, cp[11:6]};
            seq[2] = {u8v_pkg::CONT_TAG, cp[5:0]};
            return 3;
        end
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {u8v_pkg::CONT_TAG, cp[17:12]};
        seq[2] = {u8v_pkg::CONT_TAG, cp[11:6]};
        seq[3] = {u8v_pkg::CONT_TAG, cp[5:0]};
        return 4;
    endfunction

    // one random text: mostly well-formed, some cut short, corrupted or pure noise
    task automatic add_text();
        logic [7:0]      tbytes[$];
        logic [3:0][7:0] seq;
        logic [20:0]     cp;
        t_text_item      item;
        int              style;
        int              n_chars;
        int              w;
        int              k;
        int              j;
        style   = $urandom_range(0, 9);
        n_chars = $urandom_range(1, 14);
        if (style < 2) begin
            for (k = 0; k < 2 * n_chars; k++)
                tbytes.insert(tbytes.size(), 8'($urandom_range(0, 255)));
        end else begin
            for (k = 0; k < n_chars; k++) begin
                case ($urandom_range(0, 3))
                    0:       cp = 21'($urandom_range(0, 'h7F));
                    1:       cp = 21'($urandom_range('h80, 'h7FF));
                    2:       cp = $urandom_range(0, 1) ? 21'($urandom_range('h800, 'hD7FF))
                                                       : 21'($urandom_range('hE000, 'hFFFF));
                    default: cp = 21'($urandom_range('h10000, 'h10FFFF));
                endcase
                w = encode_cp(cp, seq);
                // sequence cut short at the end, or now and then mid-text
                if (w > 1 && ((style == 2 && k == n_chars - 1) ||
                              (style == 3 && $urandom_range(0, 3) == 0)))
                    w = $urandom_range(1, w - 1);
                for (j = 0; j < w; j++)
                    tbytes.insert(tbytes.size(), ($urandom_range(0, 23) == 0) ?
                                  8'($urandom_range(0, 255)) : seq[j]);
            end
        end
        for (k = 0; k < tbytes.size(); k++) begin
            item.text_byte = tbytes[k];
            item.eot       = (k == tbytes.size() - 1);
            text_q.insert(text_q.size(), item);
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        // {end_of_text, byte}
        logic [8:0] directed [26];
        t_text_item item;
        directed = '{
            9'h000, 9'h17F,
            9'h0C2, 9'h080, 9'h0C0, 9'h080,
            9'h0E0, 9'h080, 9'h080,
            9'h0ED, 9'h0A0, 9'h080,
            9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
            9'h0FF, 9'h0C2, 9'h041,
            9'h0F4, 9'h090, 9'h080, 9'h180,
            9'h0F0, 9'h090, 9'h180
        };
        foreach (directed[k]) begin
            item.text_byte = directed[k][7:0];
            item.eot       = directed[k][8];
            text_q.insert(text_q.size(), item);
        end
        while (text_q.size() < ITEM_TARGET) add_text();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || i_s_tvalid || report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // byte driver: bursts of words with random gaps
    always @(negedge i_clk) begin
        t_text_item item;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || took_byte) begin
            if (gap_left != 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (text_q.size() != 0) begin
                item = text_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= item.text_byte;
                i_s_tlast  <= item.eot;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern per phase, one long hold-off
    always @(negedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 64 == 0) rx_mode = t_rx_mode'($urandom_range(0, 2));
        if (!held_off && bytes_in >= 40 && o_m_tvalid) begin
            hold_left = HOLD_CYCLES;
            held_off  = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_m_tready <= 1'b1;
                RX_PATTERN: i_m_tready <= (rx_cyc % 3) != 0;
                default:    i_m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // monitor: check result words, predict from accepted bytes, watchdog
    always @(posedge i_clk) begin
        u8v_pkg::t_result got;
        u8v_pkg::t_result want;
        if (i_rst_n) begin
            took_byte = i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                got.kind   = o_m_tuser;
                got.offset = o_m_tdata[31:0];
                got.total  = o_m_tdata[63:32];
                got.last   = o_m_tlast;
                if (report_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: kind %0d offset %0d total %0d last %0d",
                                 got.kind, got.offset, got.total, got.last);
                end else begin
                    want = report_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected kind %0d offset %0d total %0d ",
                                      "last %0d, got kind %0d offset %0d total %0d last %0d"},
                                     want.kind, want.offset, want.total, want.last,
                                     got.kind, got.offset, got.total, got.last);
                    end
                end
            end
            if (took_byte) begin
                predict_byte(i_s_tdata, i_s_tlast);
                bytes_in++;
            end
            if (took_byte || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
